// ----- hw/rtl/vpm_pkg.sv -----
`timescale 1ns / 1ps

package vpm_pkg;

    // Field widths
    localparam int WORD_BITS  = 32;
    localparam int BIDX_BITS  = 10;
    localparam int X_BITS     = 4;
    localparam int Y_BITS     = 6;
    localparam int CNT_BITS   = 7;
    localparam int KIND_BITS  = 3;
    localparam int CFG_BITS   = 16;
    localparam int CFG_IDX_BITS = 1;

    // Default main memory depth in words
    localparam int MEM_WORDS_DEFAULT = 4096;

    // Command kinds
    localparam logic [KIND_BITS-1:0] KIND_LOAD      = 3'd0;
    localparam logic [KIND_BITS-1:0] KIND_STORE     = 3'd1;
    localparam logic [KIND_BITS-1:0] KIND_MEM_WRITE = 3'd2;
    localparam logic [KIND_BITS-1:0] KIND_MEM_READ  = 3'd3;
    localparam logic [KIND_BITS-1:0] KIND_BUF_WRITE = 3'd4;
    localparam logic [KIND_BITS-1:0] KIND_BUF_READ  = 3'd5;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_READ_PITCH   = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WRITE_STRIDE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_MOD,
        ST_HOST,
        ST_RD,
        ST_WR,
        ST_FINISH
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic latch;
        logic mod_start;
        logic advance;
        logic mem_rd;
        logic mem_wr;
        logic buf_rd;
        logic buf_wr;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [KIND_BITS-1:0] kind;
        logic                 empty;
        logic                 last_word;
        logic                 last_row;
        logic                 mod_ready;
    } dp_status_t;

endpackage

// ----- hw/rtl/vpm_mod.sv -----
`timescale 1ns / 1ps

module vpm_mod #(
    parameter int MEM_WORDS = vpm_pkg::MEM_WORDS_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [29:0]                  word,
    output logic                         ready,
    output logic [$clog2(MEM_WORDS)-1:0] index
);

    localparam int IW = $clog2(MEM_WORDS);
    localparam int WW = 30;
    localparam int PW = 2 * WW + 1;
    localparam int SH = WW + IW;
    localparam int QW = PW - SH;
    localparam int BW = WW + 2;
    localparam bit POW2 = (MEM_WORDS == (1 << IW));
    localparam logic [IW:0] MOD_M = MEM_WORDS[IW:0];
    // Reciprocal of the depth rounded up; with this shift the quotient is exact
    // for every 30-bit word
    localparam logic [63:0] RECIP_FULL = ((64'd1 << SH) + 64'(MEM_WORDS) - 64'd1)
                                       / 64'(MEM_WORDS);
    localparam logic [WW:0] RECIP = RECIP_FULL[WW:0];

    logic [1:0]    cnt_reg;
    logic [1:0]    cnt_next;
    logic [WW-1:0] div_reg;
    logic [PW-1:0] prod_reg;
    logic [PW-1:0] prod_next;
    logic [IW-1:0] rem_reg;
    logic [QW-1:0] quot;
    logic [BW-1:0] back;
    logic [BW-1:0] rem_full;

    // Multiply the word by the reciprocal
    assign prod_next = PW'(div_reg) * PW'(RECIP);

    // Take the quotient and subtract its multiple of the depth
    always_comb
    begin
        quot     = prod_reg[PW-1:SH];
        back     = BW'(quot) * BW'(MOD_M);
        rem_full = BW'(div_reg) - back;
    end

    // Step counter: a power-of-two depth resolves at load, others take two steps
    always_comb
    begin
        if (start)
        begin
            cnt_next = POW2 ? 2'd0 : 2'd2;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
        else
        begin
            cnt_next = cnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            div_reg <= word;
            rem_reg <= POW2 ? word[IW-1:0] : '0;
        end
        else if (cnt_reg == 2'd2)
        begin
            prod_reg <= prod_next;
        end
        else if (cnt_reg == 2'd1)
        begin
            rem_reg <= rem_full[IW-1:0];
        end
    end

    assign ready = (cnt_reg == '0);
    assign index = rem_reg;

endmodule

// ----- hw/rtl/vpm_datapath.sv -----
`timescale 1ns / 1ps

module vpm_datapath #(
    parameter int MEM_WORDS = vpm_pkg::MEM_WORDS_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [vpm_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [vpm_pkg::CFG_BITS-1:0]         cfg_data,
    input  logic [vpm_pkg::KIND_BITS-1:0]        kind,
    input  logic [vpm_pkg::WORD_BITS-1:0]        mem_addr,
    input  logic [vpm_pkg::BIDX_BITS-1:0]        buffer_index,
    input  logic [vpm_pkg::WORD_BITS-1:0]        write_word,
    input  logic                                 horizontal,
    input  logic [vpm_pkg::CNT_BITS-1:0]         row_count,
    input  logic [vpm_pkg::CNT_BITS-1:0]         row_length,
    input  logic [vpm_pkg::Y_BITS-1:0]           vertical_pitch,
    input  vpm_pkg::ctrl_cmd_t                   cmd,
    output vpm_pkg::dp_status_t                  status,
    output logic [vpm_pkg::WORD_BITS-1:0]        read_word
);

    localparam int IW = $clog2(MEM_WORDS);
    localparam int BUF_WORDS = 1 << vpm_pkg::BIDX_BITS;

    // Configuration
    logic [vpm_pkg::CFG_BITS-1:0] read_pitch_reg;
    logic [vpm_pkg::CFG_BITS-1:0] write_stride_reg;

    // Captured command
    logic [vpm_pkg::KIND_BITS-1:0] kind_reg;
    logic [vpm_pkg::BIDX_BITS-1:0] bidx_reg;
    logic [vpm_pkg::WORD_BITS-1:0] wword_reg;
    logic                          hor_reg;
    logic [vpm_pkg::CNT_BITS-1:0]  rows_reg;
    logic [vpm_pkg::CNT_BITS-1:0]  len_reg;
    logic [vpm_pkg::Y_BITS-1:0]    vpitch_reg;

    // Transfer walk
    logic [vpm_pkg::WORD_BITS-1:0] addr_reg;
    logic [vpm_pkg::WORD_BITS-1:0] row_base_reg;
    logic [vpm_pkg::X_BITS-1:0]    x_reg;
    logic [vpm_pkg::Y_BITS-1:0]    y_reg;
    logic [vpm_pkg::X_BITS-1:0]    row_x_reg;
    logic [vpm_pkg::Y_BITS-1:0]    row_y_reg;
    logic [vpm_pkg::CNT_BITS-1:0]  i_reg;
    logic [vpm_pkg::CNT_BITS-1:0]  r_reg;

    logic [vpm_pkg::WORD_BITS-1:0] addr_next;
    logic [vpm_pkg::WORD_BITS-1:0] row_base_next;
    logic [vpm_pkg::X_BITS-1:0]    x_next;
    logic [vpm_pkg::Y_BITS-1:0]    y_next;
    logic [vpm_pkg::X_BITS-1:0]    row_x_next;
    logic [vpm_pkg::Y_BITS-1:0]    row_y_next;
    logic [vpm_pkg::CNT_BITS-1:0]  i_next;
    logic [vpm_pkg::CNT_BITS-1:0]  r_next;

    // Memories and read data
    logic [vpm_pkg::WORD_BITS-1:0] main_mem [MEM_WORDS];
    logic [vpm_pkg::WORD_BITS-1:0] vertex_buf [BUF_WORDS];
    logic [vpm_pkg::WORD_BITS-1:0] mem_q_reg;
    logic [vpm_pkg::WORD_BITS-1:0] buf_q_reg;
    logic [vpm_pkg::WORD_BITS-1:0] mem_wdata;
    logic [vpm_pkg::WORD_BITS-1:0] buf_wdata;
    logic [vpm_pkg::BIDX_BITS-1:0] buf_addr;
    logic [IW-1:0]                 mem_idx;
    logic [29:0]                   mod_word;
    logic                          mod_ready;
    logic                          is_load;
    logic                          last_word;

    assign is_load   = (kind_reg == vpm_pkg::KIND_LOAD);
    assign last_word = (i_reg == len_reg - vpm_pkg::CNT_BITS'(1));

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            read_pitch_reg   <= '0;
            write_stride_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                vpm_pkg::CFG_READ_PITCH:   read_pitch_reg   <= cfg_data;
                vpm_pkg::CFG_WRITE_STRIDE: write_stride_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Next position: step within a row or move to the next row start
    always_comb
    begin
        addr_next     = addr_reg + 32'd4;
        row_base_next = row_base_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        row_x_next    = row_x_reg;
        row_y_next    = row_y_reg;
        i_next        = i_reg + vpm_pkg::CNT_BITS'(1);
        r_next        = r_reg;
        if (last_word)
        begin
            i_next = '0;
            r_next = r_reg + vpm_pkg::CNT_BITS'(1);
            if (hor_reg)
            begin
                row_y_next = row_y_reg + vpm_pkg::Y_BITS'(1);
            end
            else
            begin
                row_x_next = row_x_reg + vpm_pkg::X_BITS'(1);
                if (is_load)
                begin
                    row_y_next = row_y_reg + vpitch_reg;
                end
            end
            x_next = row_x_next;
            y_next = row_y_next;
            if (is_load)
            begin
                row_base_next = row_base_reg + {16'd0, read_pitch_reg};
                addr_next     = row_base_next;
            end
            else
            begin
                addr_next = addr_reg + 32'd4 + {16'd0, write_stride_reg};
            end
        end
        else if (hor_reg)
        begin
            x_next = x_reg + vpm_pkg::X_BITS'(1);
        end
        else
        begin
            y_next = y_reg + vpm_pkg::Y_BITS'(1);
        end
    end

    // Capture the command, then advance the walk
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            kind_reg     <= kind;
            bidx_reg     <= buffer_index;
            wword_reg    <= write_word;
            hor_reg      <= horizontal;
            rows_reg     <= row_count;
            len_reg      <= row_length;
            vpitch_reg   <= vertical_pitch;
            addr_reg     <= mem_addr;
            row_base_reg <= mem_addr;
            x_reg        <= buffer_index[vpm_pkg::X_BITS-1:0];
            row_x_reg    <= buffer_index[vpm_pkg::X_BITS-1:0];
            y_reg        <= buffer_index[vpm_pkg::BIDX_BITS-1:vpm_pkg::X_BITS];
            row_y_reg    <= buffer_index[vpm_pkg::BIDX_BITS-1:vpm_pkg::X_BITS];
            i_reg        <= '0;
            r_reg        <= '0;
        end
        else if (cmd.advance)
        begin
            addr_reg     <= addr_next;
            row_base_reg <= row_base_next;
            x_reg        <= x_next;
            y_reg        <= y_next;
            row_x_reg    <= row_x_next;
            row_y_reg    <= row_y_next;
            i_reg        <= i_next;
            r_reg        <= r_next;
        end
    end

    // Word index modulo the memory depth
    assign mod_word = cmd.advance ? addr_next[31:2] : addr_reg[31:2];

    vpm_mod #(
        .MEM_WORDS (MEM_WORDS)
    ) u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.mod_start),
        .word  (mod_word),
        .ready (mod_ready),
        .index (mem_idx)
    );

    // Select addresses and write data for host or transfer access
    assign buf_addr  = (kind_reg inside {vpm_pkg::KIND_BUF_WRITE, vpm_pkg::KIND_BUF_READ})
                     ? bidx_reg : {y_reg, x_reg};
    assign mem_wdata = (kind_reg == vpm_pkg::KIND_STORE) ? buf_q_reg : wword_reg;
    assign buf_wdata = is_load ? mem_q_reg : wword_reg;

    // Main memory port
    always_ff @(posedge clk)
    begin
        if (cmd.mem_wr)
        begin
            main_mem[mem_idx] <= mem_wdata;
        end
        if (cmd.mem_rd)
        begin
            mem_q_reg <= main_mem[mem_idx];
        end
    end

    // Vertex buffer port
    always_ff @(posedge clk)
    begin
        if (cmd.buf_wr)
        begin
            vertex_buf[buf_addr] <= buf_wdata;
        end
        if (cmd.buf_rd)
        begin
            buf_q_reg <= vertex_buf[buf_addr];
        end
    end

    // Result word: zero unless the command was a host memory or buffer read
    always_comb
    begin
        case (kind_reg)
            vpm_pkg::KIND_MEM_READ: read_word = mem_q_reg;
            vpm_pkg::KIND_BUF_READ: read_word = buf_q_reg;
            default:                read_word = '0;
        endcase
    end

    assign status.kind      = kind_reg;
    assign status.empty     = (rows_reg == '0) || (len_reg == '0);
    assign status.last_word = last_word;
    assign status.last_row  = (r_reg == rows_reg - vpm_pkg::CNT_BITS'(1));
    assign status.mod_ready = mod_ready;

endmodule

// ----- hw/rtl/vpm_ctrl.sv -----
`timescale 1ns / 1ps

module vpm_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  vpm_pkg::dp_status_t status,
    output vpm_pkg::ctrl_cmd_t  cmd,
    output logic                busy,
    output logic                done
);

    vpm_pkg::state_t state_reg;
    vpm_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= vpm_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Sequence host accesses and transfer words
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        done       = 1'b0;
        case (state_reg)
            vpm_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    cmd.latch  = 1'b1;
                    state_next = vpm_pkg::ST_DECODE;
                end
            end
            vpm_pkg::ST_DECODE:
            begin
                case (status.kind)
                    vpm_pkg::KIND_LOAD, vpm_pkg::KIND_STORE:
                    begin
                        if (status.empty)
                        begin
                            state_next = vpm_pkg::ST_FINISH;
                        end
                        else
                        begin
                            cmd.mod_start = 1'b1;
                            state_next    = vpm_pkg::ST_MOD;
                        end
                    end
                    vpm_pkg::KIND_MEM_WRITE, vpm_pkg::KIND_MEM_READ:
                    begin
                        cmd.mod_start = 1'b1;
                        state_next    = vpm_pkg::ST_MOD;
                    end
                    vpm_pkg::KIND_BUF_WRITE, vpm_pkg::KIND_BUF_READ:
                    begin
                        state_next = vpm_pkg::ST_HOST;
                    end
                    default:
                    begin
                        state_next = vpm_pkg::ST_FINISH;
                    end
                endcase
            end
            vpm_pkg::ST_MOD:
            begin
                if (status.mod_ready)
                begin
                    if (status.kind inside {vpm_pkg::KIND_MEM_WRITE, vpm_pkg::KIND_MEM_READ})
                    begin
                        state_next = vpm_pkg::ST_HOST;
                    end
                    else
                    begin
                        state_next = vpm_pkg::ST_RD;
                    end
                end
            end
            vpm_pkg::ST_HOST:
            begin
                case (status.kind)
                    vpm_pkg::KIND_MEM_WRITE: cmd.mem_wr = 1'b1;
                    vpm_pkg::KIND_MEM_READ:  cmd.mem_rd = 1'b1;
                    vpm_pkg::KIND_BUF_WRITE: cmd.buf_wr = 1'b1;
                    vpm_pkg::KIND_BUF_READ:  cmd.buf_rd = 1'b1;
                    default: ;
                endcase
                state_next = vpm_pkg::ST_FINISH;
            end
            vpm_pkg::ST_RD:
            begin
                if (status.kind == vpm_pkg::KIND_LOAD)
                begin
                    cmd.mem_rd = 1'b1;
                end
                else
                begin
                    cmd.buf_rd = 1'b1;
                end
                state_next = vpm_pkg::ST_WR;
            end
            vpm_pkg::ST_WR:
            begin
                if (status.kind == vpm_pkg::KIND_LOAD)
                begin
                    cmd.buf_wr = 1'b1;
                end
                else
                begin
                    cmd.mem_wr = 1'b1;
                end
                if (status.last_word && status.last_row)
                begin
                    state_next = vpm_pkg::ST_FINISH;
                end
                else
                begin
                    cmd.advance   = 1'b1;
                    cmd.mod_start = 1'b1;
                    state_next    = vpm_pkg::ST_MOD;
                end
            end
            vpm_pkg::ST_FINISH:
            begin
                done       = 1'b1;
                state_next = vpm_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = vpm_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != vpm_pkg::ST_IDLE);

    // An accepted item keeps the block busy until its result
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not make the block busy");

    // The block is free again right after a result
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("block still busy after result");

    // A transfer read only follows a resolved memory index
    a_rd_after_mod: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == vpm_pkg::ST_RD) |-> $past(status.mod_ready))
        else $error("transfer read before index resolved");

    // A transfer write always follows its read
    a_wr_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == vpm_pkg::ST_WR) |-> ($past(state_reg) == vpm_pkg::ST_RD))
        else $error("transfer write without a read");

endmodule

// ----- hw/rtl/vpm_strided_dma_engine.sv -----
`timescale 1ns / 1ps
// From accept to done: a buffer host access is decoded, then performed; a memory host
// access also resolves its memory index first. A load/store resolves the index, reads
// and writes for each word of each row; with a MEM_WORDS that is not a power of two the
// reciprocal modulo unit adds a multiply and a subtract step per index. start is taken
// only while busy is low. Reset (async, active low) clears the controller and both pitch
// registers; memory and buffer contents are undefined until written.
module vpm_strided_dma_engine #(
    parameter int MEM_WORDS = vpm_pkg::MEM_WORDS_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [vpm_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [vpm_pkg::CFG_BITS-1:0]     cfg_data,
    input  logic                             start,
    output logic                             busy,
    input  logic [vpm_pkg::KIND_BITS-1:0]    kind,
    input  logic [vpm_pkg::WORD_BITS-1:0]    mem_addr,
    input  logic [vpm_pkg::BIDX_BITS-1:0]    buffer_index,
    input  logic [vpm_pkg::WORD_BITS-1:0]    write_word,
    input  logic                             horizontal,
    input  logic [vpm_pkg::CNT_BITS-1:0]     row_count,
    input  logic [vpm_pkg::CNT_BITS-1:0]     row_length,
    input  logic [vpm_pkg::Y_BITS-1:0]       vertical_pitch,
    output logic                             done,
    output logic [vpm_pkg::WORD_BITS-1:0]    read_word
);

    vpm_pkg::ctrl_cmd_t  cmd;
    vpm_pkg::dp_status_t status;

    vpm_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    vpm_datapath #(
        .MEM_WORDS (MEM_WORDS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .kind           (kind),
        .mem_addr       (mem_addr),
        .buffer_index   (buffer_index),
        .write_word     (write_word),
        .horizontal     (horizontal),
        .row_count      (row_count),
        .row_length     (row_length),
        .vertical_pitch (vertical_pitch),
        .cmd            (cmd),
        .status         (status),
        .read_word      (read_word)
    );

endmodule

// ----- verif/tb_vpm_strided_dma_engine.sv -----
`timescale 1ns / 1ps

localparam int unsigned MEM_DEPTH = vpm_pkg::MEM_WORDS_DEFAULT;

// One command as presented on the input ports
typedef struct packed {
    logic [vpm_pkg::KIND_BITS-1:0] kind;
    logic [vpm_pkg::WORD_BITS-1:0] mem_addr;
    logic [vpm_pkg::BIDX_BITS-1:0] buffer_index;
    logic [vpm_pkg::WORD_BITS-1:0] write_word;
    logic                          horizontal;
    logic [vpm_pkg::CNT_BITS-1:0]  row_count;
    logic [vpm_pkg::CNT_BITS-1:0]  row_length;
    logic [vpm_pkg::Y_BITS-1:0]    vertical_pitch;
} dma_cmd_t;

// Shadow copy of memory, buffer and pitch registers; predicts read_word per command
class dma_mirror;
    logic [31:0] mem_image [0:MEM_DEPTH-1];
    logic [31:0] buf_image [0:1023];
    logic [15:0] read_pitch;
    logic [15:0] write_stride;
    logic [31:0] read_words_due [$];
    int unsigned errors;
    int unsigned loads;
    int unsigned stores;
    int unsigned host_ops;
    int unsigned words_moved;
    int unsigned checked;

    function new();
        read_pitch   = '0;
        write_stride = '0;
        errors       = 0;
        loads        = 0;
        stores       = 0;
        host_ops     = 0;
        words_moved  = 0;
        checked      = 0;
    endfunction

    function void set_register(logic [vpm_pkg::CFG_IDX_BITS-1:0] idx, logic [15:0] value);
        if (idx == vpm_pkg::CFG_READ_PITCH)
            read_pitch = value;
        else
            write_stride = value;
    endfunction

    function int unsigned mem_slot(logic [31:0] byte_addr);
        return (byte_addr >> 2) % MEM_DEPTH;
    endfunction

    // Apply one command to the shadow state and return the word it reads
    function logic [31:0] predict_read_word(dma_cmd_t c);
        logic [31:0] word;
        logic [31:0] a;
        logic [3:0]  x;
        logic [5:0]  y;
        int unsigned r;
        int unsigned i;
        word = '0;
        case (c.kind)
            vpm_pkg::KIND_LOAD:
            begin
                for (r = 0; r < c.row_count; r++)
                begin
                    x = c.buffer_index[3:0];
                    y = c.buffer_index[9:4];
                    if (c.horizontal)
                        y = y + 6'(r);
                    else
                    begin
                        x = x + 4'(r);
                        y = y + 6'(r * c.vertical_pitch);
                    end
                    for (i = 0; i < c.row_length; i++)
                    begin
                        a = c.mem_addr + 32'(r) * read_pitch + 32'(i * 4);
                        buf_image[{y, x}] = mem_image[mem_slot(a)];
                        if (c.horizontal)
                            x = x + 4'd1;
                        else
                            y = y + 6'd1;
                    end
                end
            end
            vpm_pkg::KIND_STORE:
            begin
                a = c.mem_addr;
                for (r = 0; r < c.row_count; r++)
                begin
                    x = c.buffer_index[3:0];
                    y = c.buffer_index[9:4];
                    // vertical rows always restart at the start y
                    if (c.horizontal)
                        y = y + 6'(r);
                    else
                        x = x + 4'(r);
                    for (i = 0; i < c.row_length; i++)
                    begin
                        mem_image[mem_slot(a)] = buf_image[{y, x}];
                        if (c.horizontal)
                            x = x + 4'd1;
                        else
                            y = y + 6'd1;
                        a = a + 32'd4;
                    end
                    a = a + 32'(write_stride);
                end
            end
            vpm_pkg::KIND_MEM_WRITE: mem_image[mem_slot(c.mem_addr)] = c.write_word;
            vpm_pkg::KIND_MEM_READ:  word = mem_image[mem_slot(c.mem_addr)];
            vpm_pkg::KIND_BUF_WRITE: buf_image[c.buffer_index] = c.write_word;
            vpm_pkg::KIND_BUF_READ:  word = buf_image[c.buffer_index];
            default: ;
        endcase
        return word;
    endfunction

    // Record an accepted item and queue its expected read_word
    function void note_command(dma_cmd_t c);
        if (c.kind == vpm_pkg::KIND_LOAD || c.kind == vpm_pkg::KIND_STORE)
        begin
            if (c.kind == vpm_pkg::KIND_LOAD)
                loads++;
            else
                stores++;
            words_moved += c.row_count * c.row_length;
        end
        else
            host_ops++;
        read_words_due.push_back(predict_read_word(c));
    endfunction

    // Compare one result against the oldest expectation
    function void check_read_word(logic [31:0] actual);
        logic [31:0] expected;
        if (read_words_due.size() == 0)
        begin
            $error("read_word: no result expected, actual %h", actual);
            errors++;
            return;
        end
        expected = read_words_due.pop_front();
        checked++;
        if (actual !== expected)
        begin
            $error("read_word mismatch: expected %h, actual %h", expected, actual);
            errors++;
        end
    endfunction

    function int unsigned pending();
        return read_words_due.size();
    endfunction
endclass

module tb_vpm_strided_dma_engine;

    localparam logic [vpm_pkg::KIND_BITS-1:0] KIND_SPARE_LO = 3'd6;
    localparam logic [vpm_pkg::KIND_BITS-1:0] KIND_SPARE_HI = 3'd7;
    localparam int STALL_LIMIT  = 60000;
    localparam int PHASE_ITEMS  = 262;
    localparam int PHASES       = 5;

    logic                             clk;
    logic                             rst_n;
    logic                             cfg_write;
    logic [vpm_pkg::CFG_IDX_BITS-1:0] cfg_index;
    logic [vpm_pkg::CFG_BITS-1:0]     cfg_data;
    logic                             start;
    logic                             busy;
    logic [vpm_pkg::KIND_BITS-1:0]    kind;
    logic [vpm_pkg::WORD_BITS-1:0]    mem_addr;
    logic [vpm_pkg::BIDX_BITS-1:0]    buffer_index;
    logic [vpm_pkg::WORD_BITS-1:0]    write_word;
    logic                             horizontal;
    logic [vpm_pkg::CNT_BITS-1:0]     row_count;
    logic [vpm_pkg::CNT_BITS-1:0]     row_length;
    logic [vpm_pkg::Y_BITS-1:0]       vertical_pitch;
    logic                             done;
    logic [vpm_pkg::WORD_BITS-1:0]    read_word;

    dma_mirror   mirror;
    bit          gaps_on;
    int unsigned accepted_items;
    int          stall_cycles;

    vpm_strided_dma_engine #(
        .MEM_WORDS(MEM_DEPTH)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .start         (start),
        .busy          (busy),
        .kind          (kind),
        .mem_addr      (mem_addr),
        .buffer_index  (buffer_index),
        .write_word    (write_word),
        .horizontal    (horizontal),
        .row_count     (row_count),
        .row_length    (row_length),
        .vertical_pitch(vertical_pitch),
        .done          (done),
        .read_word     (read_word)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Check every result strobe
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && done === 1'b1)
            mirror.check_read_word(read_word);
    end

    // Count cycles with no item and no result; give up past the limit
    always @(posedge clk)
    begin
        if (rst_n !== 1'b1 || (start === 1'b1 && busy === 1'b0) || done === 1'b1)
            stall_cycles <= 0;
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    function automatic dma_cmd_t make_cmd(input logic [vpm_pkg::KIND_BITS-1:0] k,
                                          input logic [31:0] addr,
                                          input logic [9:0] idx,
                                          input logic [31:0] word,
                                          input logic hor,
                                          input logic [6:0] rows,
                                          input logic [6:0] len,
                                          input logic [5:0] vp);
        dma_cmd_t c;
        c.kind           = k;
        c.mem_addr       = addr;
        c.buffer_index   = idx;
        c.write_word     = word;
        c.horizontal     = hor;
        c.row_count      = rows;
        c.row_length     = len;
        c.vertical_pitch = vp;
        return c;
    endfunction

    // Mostly small transfer sizes, now and then up to 64
    function automatic logic [6:0] random_count();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 85)
            return 7'($urandom_range(0, 8));
        else if (p < 97)
            return 7'($urandom_range(9, 16));
        return 7'($urandom_range(17, 64));
    endfunction

    function automatic dma_cmd_t random_command();
        dma_cmd_t    c;
        int unsigned p;
        c.mem_addr       = $urandom;
        c.buffer_index   = 10'($urandom);
        c.write_word     = $urandom;
        c.horizontal     = 1'($urandom_range(0, 1));
        c.row_count      = random_count();
        c.row_length     = random_count();
        c.vertical_pitch = 6'($urandom);
        p = $urandom_range(0, 99);
        if (p < 20)
            c.kind = vpm_pkg::KIND_LOAD;
        else if (p < 40)
            c.kind = vpm_pkg::KIND_STORE;
        else if (p < 55)
            c.kind = vpm_pkg::KIND_MEM_WRITE;
        else if (p < 70)
            c.kind = vpm_pkg::KIND_MEM_READ;
        else if (p < 85)
            c.kind = vpm_pkg::KIND_BUF_WRITE;
        else
            c.kind = vpm_pkg::KIND_BUF_READ;
        return c;
    endfunction

    // Present one item, hold it until accepted, then record it
    task automatic issue(input dma_cmd_t c);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        start          <= 1'b1;
        kind           <= c.kind;
        mem_addr       <= c.mem_addr;
        buffer_index   <= c.buffer_index;
        write_word     <= c.write_word;
        horizontal     <= c.horizontal;
        row_count      <= c.row_count;
        row_length     <= c.row_length;
        vertical_pitch <= c.vertical_pitch;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        mirror.note_command(c);
        accepted_items++;
    endtask

    // Stop issuing and wait until every queued result is back
    task automatic drain();
        start <= 1'b0;
        while (mirror.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic program_pitches(input logic [15:0] pitch, input logic [15:0] stride);
        cfg_write <= 1'b1;
        cfg_index <= vpm_pkg::CFG_READ_PITCH;
        cfg_data  <= pitch;
        @(posedge clk);
        mirror.set_register(vpm_pkg::CFG_READ_PITCH, pitch);
        cfg_index <= vpm_pkg::CFG_WRITE_STRIDE;
        cfg_data  <= stride;
        @(posedge clk);
        mirror.set_register(vpm_pkg::CFG_WRITE_STRIDE, stride);
        cfg_write <= 1'b0;
    endtask

    initial
    begin
        dma_cmd_t    c;
        dma_cmd_t    probe;
        logic [15:0] pitch;
        logic [15:0] stride;
        int          k;
        int          phase;
        int unsigned phase_base;

        mirror         = new();
        gaps_on        = 1'b1;
        accepted_items = 0;
        rst_n          <= 1'b0;
        cfg_write      <= 1'b0;
        cfg_index      <= '0;
        cfg_data       <= '0;
        start          <= 1'b0;
        kind           <= '0;
        mem_addr       <= '0;
        buffer_index   <= '0;
        write_word     <= '0;
        horizontal     <= 1'b0;
        row_count      <= '0;
        row_length     <= '0;
        vertical_pitch <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        program_pitches(16'd0, 16'd0);

        // Seed 16 memory words, spread them over the whole buffer,
        // then store the buffer four times to cover all of memory
        for (k = 0; k < 16; k++)
            issue(make_cmd(vpm_pkg::KIND_MEM_WRITE, 32'(k * 4), '0, $urandom, 1'b0,
                           '0, '0, '0));
        issue(make_cmd(vpm_pkg::KIND_LOAD, 32'd0, 10'd0, '0, 1'b1, 7'd64, 7'd16, '0));
        for (k = 0; k < 4; k++)
            issue(make_cmd(vpm_pkg::KIND_STORE, 32'(k * 4096), 10'd0, '0, 1'b1,
                           7'd64, 7'd16, '0));

        // Top address and aliasing of the memory index
        issue(make_cmd(vpm_pkg::KIND_MEM_WRITE, 32'hFFFF_FFFF, '0, 32'hFFFF_FFFF, 1'b0,
                       '0, '0, '0));
        issue(make_cmd(vpm_pkg::KIND_MEM_READ, 32'h0000_3FFC, '0, '0, 1'b1, '0, '0, '0));
        // Last buffer word
        issue(make_cmd(vpm_pkg::KIND_BUF_WRITE, '0, 10'h3FF, 32'hFFFF_FFFF, 1'b0,
                       '0, '0, '0));
        issue(make_cmd(vpm_pkg::KIND_BUF_READ, '0, 10'h3FF, '0, 1'b0, '0, '0, '0));
        // Vertical load with wrapping x, y and byte address
        issue(make_cmd(vpm_pkg::KIND_LOAD, 32'hFFFF_FFF8, 10'h3F5, '0, 1'b0,
                       7'd20, 7'd10, 6'd63));
        issue(make_cmd(vpm_pkg::KIND_BUF_READ, '0, 10'h3F5, '0, 1'b0, '0, '0, '0));
        // Empty transfers
        issue(make_cmd(vpm_pkg::KIND_LOAD, 32'h40, 10'h012, '0, 1'b1, 7'd0, 7'd64, '0));
        issue(make_cmd(vpm_pkg::KIND_STORE, 32'h80, 10'h034, '0, 1'b0, 7'd64, 7'd0, '0));
        // Vertical store running y past the bottom of the buffer
        issue(make_cmd(vpm_pkg::KIND_STORE, 32'h100, 10'h0F7, '0, 1'b0, 7'd16, 7'd64, 6'd5));
        issue(make_cmd(vpm_pkg::KIND_MEM_READ, 32'h100, '0, '0, 1'b0, '0, '0, '0));
        // A 64 by 64 horizontal load from the last buffer word
        issue(make_cmd(vpm_pkg::KIND_LOAD, 32'h2000, 10'h3FF, '0, 1'b1, 7'd64, 7'd64, '0));
        // Spare kind codes
        issue(make_cmd(KIND_SPARE_LO, $urandom, 10'($urandom), $urandom, 1'b1, '0, '0, '0));
        issue(make_cmd(KIND_SPARE_HI, $urandom, 10'($urandom), $urandom, 1'b0, '0, '0, '0));

        // Random phases, each under its own pitch setting
        for (phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    pitch  = 16'hFFFF;
                    stride = 16'hFFFF;
                end
                1:
                begin
                    pitch  = 16'd64;
                    stride = 16'd0;
                end
                2:
                begin
                    pitch  = 16'($urandom);
                    stride = 16'($urandom);
                end
                3:
                begin
                    pitch  = 16'd0;
                    stride = 16'hFFFF;
                end
                default:
                begin
                    pitch  = 16'(4 * $urandom_range(0, 32));
                    stride = 16'(4 * $urandom_range(0, 16));
                end
            endcase
            drain();
            program_pitches(pitch, stride);
            gaps_on    = (phase != PHASES - 1);
            phase_base = accepted_items;
            while (accepted_items - phase_base < PHASE_ITEMS)
            begin
                c = random_command();
                issue(c);
                // Read back part of what a transfer just wrote
                if ((c.kind == vpm_pkg::KIND_LOAD || c.kind == vpm_pkg::KIND_STORE)
                    && $urandom_range(0, 9) < 7)
                begin
                    repeat ($urandom_range(1, 3))
                    begin
                        probe = random_command();
                        if (c.kind == vpm_pkg::KIND_LOAD)
                        begin
                            probe.kind         = vpm_pkg::KIND_BUF_READ;
                            probe.buffer_index = c.buffer_index + 10'($urandom_range(0, 63));
                        end
                        else
                        begin
                            probe.kind     = vpm_pkg::KIND_MEM_READ;
                            probe.mem_addr = c.mem_addr + 32'(4 * $urandom_range(0, 63));
                        end
                        issue(probe);
                    end
                end
            end
        end

        // Wait out the last results and watch for strays
        drain();
        repeat (30) @(posedge clk);

        $display("Covered %0d items: %0d loads, %0d stores, %0d host accesses, %0d pitch settings",
                 accepted_items, mirror.loads, mirror.stores, mirror.host_ops, PHASES + 1);
        $display("Checked %0d results; %0d words moved by transfers",
                 mirror.checked, mirror.words_moved);
        if (mirror.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
